// ===== rtl/core/crl_pkg.sv =====
// ----------------------------------------------------------------------------
// crl_pkg
// Shared types and constants for the crash restart limiter.
// ----------------------------------------------------------------------------
package crl_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int HISTORY_DEPTH_DEF = 16;

   localparam logic [31:0] WINDOW_RST  = 32'd60;
   localparam logic [4:0]  BURST_RST   = 5'd5;
   localparam logic [31:0] BO_INIT_RST = 32'd1;
   localparam logic [31:0] BO_MAX_RST  = 32'd300;

   localparam int CSR_AW = 4;

   typedef enum logic [1:0] {
      CSR_WINDOW  = 2'd0,
      CSR_BURST   = 2'd1,
      CSR_BO_INIT = 2'd2,
      CSR_BO_MAX  = 2'd3
   } crl_csr_type;

   typedef enum logic [1:0] {
      OP_CRASH = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } crl_op_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_BACKOFF  = 2'd1,
      ST_DISABLED = 2'd2,
      ST_FULL     = 2'd3
   } crl_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LK_RD,
      S_LK_CHK,
      S_DISPATCH,
      S_HS_RD,
      S_HS_CHK,
      S_APPEND,
      S_BACKOFF,
      S_FINISH,
      S_DONE
   } crl_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] entry_key;
      logic [31:0] now_time;
   } crl_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] wait_seconds;
      logic [4:0]  crash_count;
   } crl_rsp_type;

   typedef struct packed {
      logic [31:0] window_seconds;
      logic [4:0]  burst_limit;
      logic [31:0] backoff_initial;
      logic [31:0] backoff_max;
   } crl_cfg_type;

endpackage

// ===== rtl/core/crl_ram.sv =====
// ----------------------------------------------------------------------------
// crl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module crl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/crl_engine.sv =====
// ----------------------------------------------------------------------------
// crl_engine
// Sequencer: record lookup, history compaction, backoff doubling, write back.
// ----------------------------------------------------------------------------
module crl_engine
   import crl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  crl_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  crl_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output crl_rsp_type rsp_payload
);

   localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW  = $clog2(HISTORY_DEPTH + 1);
   localparam int TD  = TABLE_ENTRIES * HISTORY_DEPTH;
   localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
   // record word: identity, held count, retry time, disabled
   localparam int RW  = 16 + CW + 32 + 1;

   crl_state_type state_ff, state_in;

   logic [1:0]         op_ff, op_in;
   logic [15:0]        key_ff, key_in;
   logic [31:0]        now_ff, now_in;
   logic [EW-1:0]      idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic               free_ok_ff, free_ok_in;
   logic [EW-1:0]      free_idx_ff, free_idx_in;
   logic [EW-1:0]      ent_ff, ent_in;
   logic [CW-1:0]      held_ff, held_in;
   logic [31:0]        retry_ff, retry_in;
   logic               dis_ff, dis_in;
   logic [CW-1:0]      hidx_ff, hidx_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [31:0]        bo_ff, bo_in;
   crl_rsp_type        res_ff, res_in;
   crl_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // memory ports
   logic            rec_we;
   logic [EW-1:0]   rec_waddr, rec_raddr;
   logic [RW-1:0]   rec_wdata, rec_q;
   logic            tm_we;
   logic [TAW-1:0]  tm_waddr, tm_raddr;
   logic [31:0]     tm_wdata, tm_q;

   logic [15:0]     q_ident;
   logic [CW-1:0]   q_held;
   logic [31:0]     q_retry;
   logic            q_dis;
   logic [TAW-1:0]  tm_base;
   logic [31:0]     bo_half, bo_dbl, bo_step;
   logic            ovf, keep;

   crl_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_q)
   );

   crl_ram #(.WIDTH(32), .DEPTH(TD)) u_time_ram (
      .clock   (clock),
      .wr_en   (tm_we),
      .wr_addr (tm_waddr),
      .wr_data (tm_wdata),
      .rd_addr (tm_raddr),
      .rd_data (tm_q)
   );

   assign {q_ident, q_held, q_retry, q_dis} = rec_q;
   assign tm_base = TAW'(ent_ff) * TAW'(HISTORY_DEPTH);

   assign bo_half = cfg.backoff_max >> 1;
   assign bo_dbl  = (bo_ff > bo_half) ? cfg.backoff_max : {bo_ff[30:0], 1'b0};
   assign bo_step = (bo_dbl > cfg.backoff_max) ? cfg.backoff_max : bo_dbl;
   assign ovf     = bo_ff > ~now_ff;
   assign keep    = (now_ff >= tm_q) && ((now_ff - tm_q) <= cfg.window_seconds);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      ent_ff      <= ent_in;
      held_ff     <= held_in;
      retry_ff    <= retry_in;
      dis_ff      <= dis_in;
      hidx_ff     <= hidx_in;
      n_ff        <= n_in;
      bo_ff       <= bo_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      ent_in       = ent_ff;
      held_in      = held_ff;
      retry_in     = retry_ff;
      dis_in       = dis_ff;
      hidx_in      = hidx_ff;
      n_in         = n_ff;
      bo_in        = bo_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      rec_we       = 1'b0;
      rec_waddr    = ent_ff;
      rec_wdata    = {key_ff, n_ff, retry_ff, dis_ff};
      rec_raddr    = idx_ff;
      tm_we        = 1'b0;
      tm_waddr     = tm_base + TAW'(n_ff[IW-1:0]);
      tm_wdata     = now_ff;
      tm_raddr     = tm_base + TAW'(hidx_ff[IW-1:0]);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_payload.req_type;
               key_in     = req_payload.entry_key;
               now_in     = req_payload.now_time;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               state_in   = S_LK_RD;
            end
         end
         S_LK_RD: begin
            state_in = S_LK_CHK;
         end
         S_LK_CHK: begin
            if (valid_ff[idx_ff] && q_ident == key_ff) begin
               hit_in   = 1'b1;
               ent_in   = idx_ff;
               held_in  = q_held;
               retry_in = q_retry;
               dis_in   = q_dis;
               state_in = S_DISPATCH;
            end else begin
               if (!valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (idx_ff == EW'(TABLE_ENTRIES - 1)) begin
                  state_in = S_DISPATCH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LK_RD;
               end
            end
         end
         S_DISPATCH: begin
            res_in   = '{status: ST_ACCEPTED, wait_seconds: '0, crash_count: '0};
            state_in = S_DONE;
            hidx_in  = '0;
            n_in     = '0;
            case (op_ff)
               OP_CRASH: begin
                  if (hit_ff || free_ok_ff) begin
                     if (!hit_ff) begin
                        // new record
                        ent_in   = free_idx_ff;
                        held_in  = '0;
                        retry_in = '0;
                        dis_in   = 1'b0;
                     end
                     state_in = (hit_ff && held_ff != '0) ? S_HS_RD : S_APPEND;
                  end else begin
                     res_in.status = ST_FULL;
                  end
               end
               OP_QUERY: begin
                  if (hit_ff) begin
                     res_in.crash_count = 5'(held_ff);
                     if (dis_ff) begin
                        res_in.status = ST_DISABLED;
                     end else if (now_ff < retry_ff) begin
                        res_in.status       = ST_BACKOFF;
                        res_in.wait_seconds = retry_ff - now_ff;
                     end
                  end
               end
               OP_CLEAR: begin
                  if (hit_ff) begin
                     valid_in[ent_ff] = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_HS_RD: begin
            state_in = S_HS_CHK;
         end
         S_HS_CHK: begin
            // compact in place: write slot never passes read slot
            if (keep) begin
               tm_we    = 1'b1;
               tm_wdata = tm_q;
               n_in     = n_ff + 1'b1;
            end
            hidx_in  = hidx_ff + 1'b1;
            state_in = (hidx_in == held_ff) ? S_APPEND : S_HS_RD;
         end
         S_APPEND: begin
            if (n_ff < CW'(HISTORY_DEPTH)) begin
               tm_we = 1'b1;
               n_in  = n_ff + 1'b1;
            end
            bo_in    = cfg.backoff_initial;
            hidx_in  = CW'(1);
            state_in = S_BACKOFF;
         end
         S_BACKOFF: begin
            if (hidx_ff < n_ff) begin
               bo_in   = bo_step;
               hidx_in = hidx_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            dis_in = (32'(n_ff) >= 32'(cfg.burst_limit)) || ovf;
            if (!ovf) begin
               retry_in = now_ff + bo_ff;
            end
            rec_we             = 1'b1;
            rec_wdata          = {key_ff, n_ff, retry_in, dis_in};
            valid_in[ent_ff]   = 1'b1;
            res_in.status       = dis_in ? ST_DISABLED : ST_BACKOFF;
            res_in.wait_seconds = bo_ff;
            res_in.crash_count  = 5'(n_ff);
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done state");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(HISTORY_DEPTH) || state_ff == S_IDLE || state_ff == S_LK_RD
      || state_ff == S_LK_CHK || state_ff == S_DISPATCH)
      else $error("history count beyond depth");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH |=> valid_ff[$past(ent_ff)])
      else $error("record not valid after crash write back");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HS_CHK |-> n_ff <= hidx_ff)
      else $error("compaction write passed read slot");

endmodule

// ===== rtl/core/crash_restart_limiter.sv =====
// ----------------------------------------------------------------------------
// crash_restart_limiter
// Restart rate limiter with exponential backoff, register file and engine.
// ----------------------------------------------------------------------------
// Sequence: lookup reads and compares table entries in turn (record RAM read,
//   compare) until a hit or the last entry. A crash report then compacts the
//   held times (read, check), appends, doubles the backoff per recorded time
//   after the first, then writes back. One item in flight at a time.
// Reset: synchronous; registers return to defaults, all records invalid.
module crash_restart_limiter
   import crl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  crl_req_type       req_payload,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output crl_rsp_type       rsp_payload,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   crl_cfg_type cfg_ff, cfg_in;
   logic        wr_xfer;
   logic [1:0]  reg_sel;

   // Register index is the word address; byte offset bits are ignored.
   assign reg_sel = paddr[3:2];
   assign wr_xfer = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_seconds  <= WINDOW_RST;
         cfg_ff.burst_limit     <= BURST_RST;
         cfg_ff.backoff_initial <= BO_INIT_RST;
         cfg_ff.backoff_max     <= BO_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         case (reg_sel)
            CSR_WINDOW:  cfg_in.window_seconds  = pwdata;
            CSR_BURST:   cfg_in.burst_limit     = pwdata[4:0];
            CSR_BO_INIT: cfg_in.backoff_initial = pwdata;
            CSR_BO_MAX:  cfg_in.backoff_max     = pwdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back is combinational on the selected register.
   always_comb begin
      case (reg_sel)
         CSR_WINDOW:  prdata = cfg_ff.window_seconds;
         CSR_BURST:   prdata = {27'd0, cfg_ff.burst_limit};
         CSR_BO_INIT: prdata = cfg_ff.backoff_initial;
         CSR_BO_MAX:  prdata = cfg_ff.backoff_max;
         default:     prdata = '0;
      endcase
   end

   // Engine holds the record and history RAMs and the sequencer.
   crl_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
